@@ hdl/modular_inverse_fermat_top_macros.svh @@
// Assertion helpers shared by the modular inverse design.
// Both expect a clock named clock and an active-high reset named reset in scope.
`ifndef MODULAR_INVERSE_FERMAT_TOP_MACROS_SVH
`define MODULAR_INVERSE_FERMAT_TOP_MACROS_SVH

// Same-cycle implication.
`define MIF_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// Next-cycle implication.
`define MIF_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

@@ hdl/mif_pkg.sv @@
package mif_pkg;

   // Fixed widths of the item fields and the register port.
   localparam int DATA_BITS      = 64;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_INDEX_LSB  = 3;
   localparam logic [CSR_ADDR_BITS-CSR_INDEX_LSB-1:0] REG_PRIME_MODULUS = 1'b0;
   localparam logic [DATA_BITS-1:0] PRIME_MODULUS_RESET = 64'd2;

   // Sequencer program counter.
   localparam int PC_BITS = 4;
   typedef logic [PC_BITS-1:0] pc_type;

   // What one step of the program does.
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_WAIT_REQ,
      ACT_REDUCE,
      ACT_MUL_ACC,
      ACT_SQUARE,
      ACT_EMIT_ACC,
      ACT_EMIT_ZERO
   } action_type;

   // Condition under which a finished step jumps to its target.
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_P_LOW,
      COND_EXP_ZERO,
      COND_EXP_EVEN
   } cond_type;

   typedef struct packed {
      action_type action;
      cond_type   cond;
      pc_type     target;
   } ctrl_word_type;

   // Program addresses.
   localparam pc_type STEP_IDLE      = 4'd0;
   localparam pc_type STEP_CHECK_P   = 4'd1;
   localparam pc_type STEP_REDUCE    = 4'd2;
   localparam pc_type STEP_TEST_EXP  = 4'd3;
   localparam pc_type STEP_TEST_BIT  = 4'd4;
   localparam pc_type STEP_MUL_ACC   = 4'd5;
   localparam pc_type STEP_SQUARE    = 4'd6;
   localparam pc_type STEP_EMIT_ACC  = 4'd7;
   localparam pc_type STEP_EMIT_ZERO = 4'd8;

   // The control store: right-to-left square-and-multiply.
   function automatic ctrl_word_type microcode(input pc_type pc);
      ctrl_word_type w;
      case (pc)
         STEP_IDLE:      w = '{action: ACT_WAIT_REQ,  cond: COND_NEVER,    target: STEP_IDLE};
         STEP_CHECK_P:   w = '{action: ACT_NONE,      cond: COND_P_LOW,    target: STEP_EMIT_ZERO};
         STEP_REDUCE:    w = '{action: ACT_REDUCE,    cond: COND_NEVER,    target: STEP_IDLE};
         STEP_TEST_EXP:  w = '{action: ACT_NONE,      cond: COND_EXP_ZERO, target: STEP_EMIT_ACC};
         STEP_TEST_BIT:  w = '{action: ACT_NONE,      cond: COND_EXP_EVEN, target: STEP_SQUARE};
         STEP_MUL_ACC:   w = '{action: ACT_MUL_ACC,   cond: COND_NEVER,    target: STEP_IDLE};
         STEP_SQUARE:    w = '{action: ACT_SQUARE,    cond: COND_ALWAYS,   target: STEP_TEST_EXP};
         STEP_EMIT_ACC:  w = '{action: ACT_EMIT_ACC,  cond: COND_ALWAYS,   target: STEP_IDLE};
         STEP_EMIT_ZERO: w = '{action: ACT_EMIT_ZERO, cond: COND_ALWAYS,   target: STEP_IDLE};
         default:        w = '{action: ACT_NONE,      cond: COND_ALWAYS,   target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

@@ hdl/mif_channel_if.sv @@
// Operand channel.
interface mif_req_if;
   logic                           valid;
   logic                           ready;
   logic [mif_pkg::DATA_BITS-1:0]  operand_value;

   modport source (output valid, output operand_value, input ready);
   modport sink (input valid, input operand_value, output ready);
endinterface

// Result channel.
interface mif_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mif_pkg::DATA_BITS-1:0]  inverse_value;

   modport source (output valid, output inverse_value, input ready);
   modport sink (input valid, input inverse_value, output ready);
endinterface

@@ hdl/mif_modmul.sv @@
`include "modular_inverse_fermat_top_macros.svh"

// Bit-serial interleaved modular multiplier: one bit of y per cycle, MSB first.
// Operands must be below p, and p at least two.
module mif_modmul #(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] x,
   input  logic [WIDTH-1:0] y,
   input  logic [WIDTH-1:0] p,
   output logic             done,
   output logic [WIDTH-1:0] product
);

   localparam int CNT_BITS = $clog2(WIDTH);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WIDTH - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0]    acc_ff, acc_in;
   logic [WIDTH-1:0]    x_ff, x_in;
   logic [WIDTH-1:0]    y_ff, y_in;
   logic [WIDTH-1:0]    dbl;
   logic [WIDTH-1:0]    step;

   // (a + b) mod p for a, b below p; the extra bit keeps the carry.
   function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                                input logic [WIDTH-1:0] b,
                                                input logic [WIDTH-1:0] m);
      logic [WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[WIDTH-1:0];
   endfunction

   // Double the partial result, then add x when the current bit of y is set.
   always_comb begin
      dbl  = add_mod(acc_ff, acc_ff, p);
      step = y_ff[WIDTH-1] ? add_mod(dbl, x_ff, p) : dbl;
   end

   // Next-state logic for the iteration.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         x_in    = x;
         y_in    = y;
      end else if (busy_ff) begin
         acc_in = step;
         y_in   = y_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

   `MIF_ASSERT_IMP(a_start_when_free, start, !busy_ff)
   `MIF_ASSERT_IMP(a_partial_reduced, busy_ff, acc_ff < p && x_ff < p)
   `MIF_ASSERT_NXT(a_done_single_pulse, done_ff, !done_ff)

endmodule

@@ hdl/modular_inverse_fermat_top.sv @@
// Modular inverse by Fermat's little theorem: returns (operand mod p)^(p-2) mod p for the
// modulus p in register prime_modulus (byte address 0, 64 bits; only the low WIDTH bits are
// used, as for the operand). A modulus below two yields 0. One operand is processed at a
// time; the next is taken once the current result has moved into the output register. Every
// modular product goes through one shared bit-serial multiplier that handles one bit per
// cycle. An item starts with the initial reduction of the operand and then, for each of the
// significant bits of p-2 from the least significant up, tests the bit, multiplies the
// accumulator by the base when the bit is set, and squares the base.
`include "modular_inverse_fermat_top_macros.svh"

module modular_inverse_fermat_top #(
   parameter int WIDTH = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   mif_req_if.sink                                req_chan,
   mif_rsp_if.source                              rsp_chan,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [mif_pkg::CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [mif_pkg::DATA_BITS-1:0]          csr_pwdata,
   output logic [mif_pkg::DATA_BITS-1:0]          csr_prdata,
   output logic                                   csr_pready
);

   localparam logic [WIDTH-1:0] ONE = WIDTH'(1);
   localparam logic [WIDTH-1:0] TWO = WIDTH'(2);

   mif_pkg::ctrl_word_type        word;
   mif_pkg::pc_type               pc_ff, pc_in;
   logic                          issued_ff, issued_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0]              inverse_ff, inverse_in;
   logic [mif_pkg::DATA_BITS-1:0] modulus_ff, modulus_in;
   logic [WIDTH-1:0]              operand_ff, operand_in;
   logic [WIDTH-1:0]              base_ff, base_in;
   logic [WIDTH-1:0]              acc_ff, acc_in;
   logic [WIDTH-1:0]              exp_ff, exp_in;
   logic [WIDTH-1:0]              p_w;
   logic                          is_mul;
   logic                          step_done;
   logic                          cond_true;
   logic                          req_xfer;
   logic                          csr_write;
   logic                          mul_start;
   logic                          mul_done;
   logic [WIDTH-1:0]              mul_x;
   logic [WIDTH-1:0]              mul_y;
   logic [WIDTH-1:0]              mul_product;

   assign p_w = modulus_ff[WIDTH-1:0];

   // Configuration register port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[mif_pkg::CSR_ADDR_BITS-1:mif_pkg::CSR_INDEX_LSB]
                           == mif_pkg::REG_PRIME_MODULUS);
   assign modulus_in = csr_write ? csr_pwdata : modulus_ff;
   assign csr_prdata = (csr_paddr[mif_pkg::CSR_ADDR_BITS-1:mif_pkg::CSR_INDEX_LSB]
                        == mif_pkg::REG_PRIME_MODULUS) ? modulus_ff : '0;

   // Fetch the control word of the current step.
   assign word     = mif_pkg::microcode(pc_ff);
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (word.action == mif_pkg::ACT_WAIT_REQ);

   // Step completion and jump condition.
   always_comb begin
      is_mul = 1'b0;
      case (word.action)
         mif_pkg::ACT_REDUCE, mif_pkg::ACT_MUL_ACC, mif_pkg::ACT_SQUARE: begin
            is_mul    = 1'b1;
            step_done = mul_done;
         end
         mif_pkg::ACT_WAIT_REQ: begin
            step_done = req_xfer;
         end
         mif_pkg::ACT_EMIT_ACC, mif_pkg::ACT_EMIT_ZERO: begin
            step_done = !rsp_valid_ff;
         end
         default: begin
            step_done = 1'b1;
         end
      endcase

      case (word.cond)
         mif_pkg::COND_ALWAYS:   cond_true = 1'b1;
         mif_pkg::COND_P_LOW:    cond_true = (p_w < TWO);
         mif_pkg::COND_EXP_ZERO: cond_true = (exp_ff == '0);
         mif_pkg::COND_EXP_EVEN: cond_true = !exp_ff[0];
         default:                cond_true = 1'b0;
      endcase

      if (!step_done) begin
         pc_in = pc_ff;
      end else if (cond_true) begin
         pc_in = word.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   // Multiplier issue and operand selection.
   assign mul_start = is_mul && !issued_ff;
   assign issued_in = is_mul && !mul_done;

   always_comb begin
      case (word.action)
         mif_pkg::ACT_REDUCE: begin
            mul_x = ONE;
            mul_y = operand_ff;
         end
         mif_pkg::ACT_MUL_ACC: begin
            mul_x = acc_ff;
            mul_y = base_ff;
         end
         default: begin
            mul_x = base_ff;
            mul_y = base_ff;
         end
      endcase
   end

   // Working registers of the exponentiation.
   always_comb begin
      operand_in = operand_ff;
      base_in    = base_ff;
      acc_in     = acc_ff;
      exp_in     = exp_ff;
      if (req_xfer) begin
         operand_in = req_chan.operand_value[WIDTH-1:0];
      end
      if (mul_start && word.action == mif_pkg::ACT_REDUCE) begin
         acc_in = ONE;
         exp_in = p_w - TWO;
      end
      if (mul_done) begin
         case (word.action)
            mif_pkg::ACT_REDUCE: begin
               base_in = mul_product;
            end
            mif_pkg::ACT_MUL_ACC: begin
               acc_in = mul_product;
            end
            mif_pkg::ACT_SQUARE: begin
               base_in = mul_product;
               exp_in  = exp_ff >> 1;
            end
            default: begin
               base_in = base_ff;
            end
         endcase
      end
   end

   // Output register: filled by an emit step, emptied by a result transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      inverse_in   = inverse_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (step_done && word.action == mif_pkg::ACT_EMIT_ACC) begin
         rsp_valid_in = 1'b1;
         inverse_in   = acc_ff;
      end else if (step_done && word.action == mif_pkg::ACT_EMIT_ZERO) begin
         rsp_valid_in = 1'b1;
         inverse_in   = '0;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.inverse_value = mif_pkg::DATA_BITS'(inverse_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= mif_pkg::STEP_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= mif_pkg::PRIME_MODULUS_RESET;
      end else begin
         pc_ff        <= pc_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         modulus_ff   <= modulus_in;
      end
   end

   always_ff @(posedge clock) begin
      operand_ff <= operand_in;
      base_ff    <= base_in;
      acc_ff     <= acc_in;
      exp_ff     <= exp_in;
      inverse_ff <= inverse_in;
   end

   mif_modmul #(
      .WIDTH (WIDTH)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .x       (mul_x),
      .y       (mul_y),
      .p       (p_w),
      .done    (mul_done),
      .product (mul_product)
   );

   `MIF_ASSERT_IMP(a_done_matches_issue, mul_done, issued_ff)
   `MIF_ASSERT_IMP(a_issue_in_mul_step, issued_ff, is_mul)
   `MIF_ASSERT_IMP(a_loop_values_reduced, pc_ff == mif_pkg::STEP_TEST_EXP,
                   acc_ff < p_w && base_ff < p_w)

endmodule
